// ===== hdl/vco_pkg.sv =====
// ----------------------------------------------------------------------------
// vco_pkg - shared types and constants for the cylinder outside test
// Field widths, fixed-point shifts, register codes and pipeline payloads.
// ----------------------------------------------------------------------------
`default_nettype none

package vco_pkg;

  // Field and register widths
  localparam int LANE_W      = 16;
  localparam int IDX_W       = 12;
  localparam int REG_W       = 48;
  localparam int RADIUS_W    = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 16;

  // Datapath widths (all exact, nothing wraps for any input pattern)
  localparam int PROD_W = 32;   // rotation entry times coordinate
  localparam int OFF_W  = 17;   // centre minus axis origin
  localparam int WQ_W   = 34;   // rotated, shifted position, Q.22
  localparam int AXW_W  = 50;   // axial projection terms and sum, Q.36
  localparam int D_W    = 66;   // perpendicular component, Q.50
  localparam int MAG_W  = 64;   // magnitude of perpendicular component
  localparam int HALF_W = 32;   // half of a magnitude for the split square
  localparam int SQ_W   = 128;  // square of one component, Q.100
  localparam int SUM_W  = 130;  // squared distance, Q.100
  localparam int R2_W   = 32;   // radius squared, Q.16

  // Fixed-point alignment shifts
  localparam int OFF_SHIFT = 14;  // Q8.8 offset to Q.22
  localparam int WQ_SHIFT  = 28;  // Q.22 position to Q.50
  localparam int THR_SHIFT = 84;  // Q.16 radius squared to Q.100

  // Register reset values
  localparam logic [REG_W-1:0]    ROW_A_RST  = 48'h0000_0000_4000;
  localparam logic [REG_W-1:0]    ROW_B_RST  = 48'h0000_4000_0000;
  localparam logic [REG_W-1:0]    ROW_C_RST  = 48'h4000_0000_0000;
  localparam logic [REG_W-1:0]    AXIS_RST   = 48'h4000_0000_0000;
  localparam logic [RADIUS_W-1:0] RADIUS_RST = 16'd256;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_A,
    CFG_ROW_B,
    CFG_ROW_C,
    CFG_CENTRE,
    CFG_ORIGIN,
    CFG_AXIS,
    CFG_RADIUS
  } cfg_reg_e;

  // Three 16-bit lanes, x in the lowest bits
  typedef logic [2:0][LANE_W-1:0] lane3_t;

  typedef struct packed {
    lane3_t [2:0]        rows;
    lane3_t              centre;
    lane3_t              origin;
    lane3_t              axis;
    logic [RADIUS_W-1:0] radius;
  } cfg_t;

  typedef struct packed {
    logic [LANE_W-1:0] z;
    logic [LANE_W-1:0] y;
    logic [LANE_W-1:0] x;
    logic [IDX_W-1:0]  idx;
  } in_item_t;

  typedef struct packed {
    logic [2:0][WQ_W-1:0] wq;
    logic [IDX_W-1:0]     idx;
  } rot_item_t;

  typedef struct packed {
    logic [2:0][D_W-1:0] d;
    logic [IDX_W-1:0]    idx;
  } proj_item_t;

endpackage

`default_nettype wire

// ===== hdl/vco_rot.sv =====
// ----------------------------------------------------------------------------
// vco_rot - rotate and translate one vertex
// Two stages: nine rotation products, then row sums plus centre-origin offset.
// ----------------------------------------------------------------------------
`default_nettype none

module vco_rot import vco_pkg::*; #(
  parameter int MAX_VERTS   = 4096,
  parameter int COORD_WIDTH = 16
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cfg_t      cfg,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output rot_item_t      out_item
);

  localparam int CoordBits = (COORD_WIDTH < LANE_W) ? COORD_WIDTH : LANE_W;
  localparam int ExtShift  = LANE_W - CoordBits;

  logic                     va, vb;
  logic                     rdy_a, rdy_b;
  logic                     in_range;
  lane3_t                   raw;
  logic signed [LANE_W-1:0] p [3];
  logic signed [LANE_W-1:0] p_shl [3];

  logic [IDX_W-1:0]         a_idx;
  logic signed [PROD_W-1:0] prod [3][3];
  logic signed [OFF_W-1:0]  offs [3];

  // Stage handshake: a stage loads when it is empty or its successor moves
  assign rdy_b     = !vb || out_ready;
  assign rdy_a     = !va || rdy_b;
  assign in_ready  = rdy_a;
  assign out_valid = vb;

  // Drop vertices beyond the mesh
  assign in_range = ({20'd0, in_item.idx} < 32'(MAX_VERTS));

  // Sign-extend coordinates at the configured coordinate width
  always_comb begin
    raw[0] = in_item.x;
    raw[1] = in_item.y;
    raw[2] = in_item.z;
    for (int k = 0; k < 3; k++) begin
      p_shl[k] = $signed(raw[k] << ExtShift);
      p[k]     = p_shl[k] >>> ExtShift;
    end
  end

  // Stage A: rotation products and translation offset
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (rdy_a) begin
      va <= in_valid && in_range;
    end
    if (rdy_a && in_valid) begin
      a_idx <= in_item.idx;
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          prod[i][k] <= PROD_W'($signed(cfg.rows[i][k])) * PROD_W'(p[k]);
        end
        offs[i] <= $signed({cfg.centre[i][LANE_W-1], cfg.centre[i]})
                 - $signed({cfg.origin[i][LANE_W-1], cfg.origin[i]});
      end
    end
  end

  // Stage B: row sums give the position relative to the axis origin
  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (rdy_b) begin
      vb <= va;
    end
    if (rdy_b && va) begin
      out_item.idx <= a_idx;
      for (int i = 0; i < 3; i++) begin
        out_item.wq[i] <= WQ_W'(prod[i][0]) + WQ_W'(prod[i][1]) + WQ_W'(prod[i][2])
                        + (WQ_W'(offs[i]) <<< OFF_SHIFT);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/vco_proj.sv =====
// ----------------------------------------------------------------------------
// vco_proj - remove the axial component of a position
// Four stages: axis products, dot product, scaled axis, perpendicular part.
// ----------------------------------------------------------------------------
`default_nettype none

module vco_proj import vco_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cfg_t      cfg,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire rot_item_t in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output proj_item_t     out_item
);

  logic vc, vd, ve, vf;
  logic rdy_c, rdy_d, rdy_e, rdy_f;

  rot_item_t               c_item, d_item, e_item;
  logic signed [AXW_W-1:0] axw [3];
  logic signed [AXW_W-1:0] pdot;
  logic signed [D_W-1:0]   pa [3];

  // Stage handshake
  assign rdy_f     = !vf || out_ready;
  assign rdy_e     = !ve || rdy_f;
  assign rdy_d     = !vd || rdy_e;
  assign rdy_c     = !vc || rdy_d;
  assign in_ready  = rdy_c;
  assign out_valid = vf;

  // Stage C: axis component times position component
  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (rdy_c) begin
      vc <= in_valid;
    end
    if (rdy_c && in_valid) begin
      c_item <= in_item;
      for (int i = 0; i < 3; i++) begin
        axw[i] <= AXW_W'($signed(cfg.axis[i])) * AXW_W'($signed(in_item.wq[i]));
      end
    end
  end

  // Stage D: sum into the axial distance
  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (rdy_d) begin
      vd <= vc;
    end
    if (rdy_d && vc) begin
      d_item <= c_item;
      pdot   <= axw[0] + axw[1] + axw[2];
    end
  end

  // Stage E: axial distance back along the axis
  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else if (rdy_e) begin
      ve <= vd;
    end
    if (rdy_e && vd) begin
      e_item <= d_item;
      for (int i = 0; i < 3; i++) begin
        pa[i] <= D_W'(pdot) * D_W'($signed(cfg.axis[i]));
      end
    end
  end

  // Stage F: perpendicular component at a common scale
  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else if (rdy_f) begin
      vf <= ve;
    end
    if (rdy_f && ve) begin
      out_item.idx <= e_item.idx;
      for (int i = 0; i < 3; i++) begin
        out_item.d[i] <= (D_W'($signed(e_item.wq[i])) <<< WQ_SHIFT) - pa[i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/vco_dist.sv =====
// ----------------------------------------------------------------------------
// vco_dist - squared perpendicular distance against radius squared
// Five stages: magnitude, split square, square assembly, sum, compare. The
// last stage is the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vco_dist import vco_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire proj_item_t  in_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [IDX_W-1:0] out_idx
);

  logic vg, vh, vi, vj, vk;
  logic rdy_g, rdy_h, rdy_i, rdy_j, rdy_k;

  logic [IDX_W-1:0]    g_idx, h_idx, i_idx, j_idx;
  logic signed [D_W-1:0] dneg [3];
  logic [MAG_W-1:0]    mag_next [3];
  logic [MAG_W-1:0]    mag [3];
  logic [MAG_W-1:0]    hh [3];
  logic [MAG_W-1:0]    hl [3];
  logic [MAG_W-1:0]    ll [3];
  logic [SQ_W-1:0]     sq [3];
  logic [SUM_W-1:0]    total;
  logic [R2_W-1:0]     r2;
  logic                outside;

  // Stage handshake
  assign rdy_k     = !vk || out_ready;
  assign rdy_j     = !vj || rdy_k;
  assign rdy_i     = !vi || rdy_j;
  assign rdy_h     = !vh || rdy_i;
  assign rdy_g     = !vg || rdy_h;
  assign in_ready  = rdy_g;
  assign out_valid = vk;

  // Radius squared follows the radius register
  always_ff @(posedge clk) begin
    r2 <= R2_W'(cfg.radius) * R2_W'(cfg.radius);
  end

  // Magnitude of each component
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dneg[i]     = -$signed(in_item.d[i]);
      mag_next[i] = in_item.d[i][D_W-1] ? dneg[i][MAG_W-1:0] : in_item.d[i][MAG_W-1:0];
    end
  end

  // Stage G: magnitudes
  always_ff @(posedge clk) begin
    if (rst) begin
      vg <= 1'b0;
    end else if (rdy_g) begin
      vg <= in_valid;
    end
    if (rdy_g && in_valid) begin
      g_idx <= in_item.idx;
      for (int i = 0; i < 3; i++) begin
        mag[i] <= mag_next[i];
      end
    end
  end

  // Stage H: half-word partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      vh <= 1'b0;
    end else if (rdy_h) begin
      vh <= vg;
    end
    if (rdy_h && vg) begin
      h_idx <= g_idx;
      for (int i = 0; i < 3; i++) begin
        hh[i] <= MAG_W'(mag[i][MAG_W-1:HALF_W]) * MAG_W'(mag[i][MAG_W-1:HALF_W]);
        hl[i] <= MAG_W'(mag[i][MAG_W-1:HALF_W]) * MAG_W'(mag[i][HALF_W-1:0]);
        ll[i] <= MAG_W'(mag[i][HALF_W-1:0]) * MAG_W'(mag[i][HALF_W-1:0]);
      end
    end
  end

  // Stage I: assemble each square
  always_ff @(posedge clk) begin
    if (rst) begin
      vi <= 1'b0;
    end else if (rdy_i) begin
      vi <= vh;
    end
    if (rdy_i && vh) begin
      i_idx <= h_idx;
      for (int i = 0; i < 3; i++) begin
        sq[i] <= (SQ_W'(hh[i]) << (2 * HALF_W)) + (SQ_W'(hl[i]) << (HALF_W + 1))
               + SQ_W'(ll[i]);
      end
    end
  end

  // Stage J: squared distance
  always_ff @(posedge clk) begin
    if (rst) begin
      vj <= 1'b0;
    end else if (rdy_j) begin
      vj <= vi;
    end
    if (rdy_j && vi) begin
      j_idx <= i_idx;
      total <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
    end
  end

  // Threshold has zero low bits, so only the upper part of the sum matters
  assign outside = (total[SUM_W-1:THR_SHIFT] >= (SUM_W - THR_SHIFT)'(r2));

  // Stage K: output register, drop vertices inside the radius
  always_ff @(posedge clk) begin
    if (rst) begin
      vk <= 1'b0;
    end else if (rdy_k) begin
      vk <= vj && outside;
    end
    if (rdy_k && vj) begin
      out_idx <= j_idx;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/vertex_cylinder_outside_test.sv =====
// ----------------------------------------------------------------------------
// vertex_cylinder_outside_test - flag hull vertices outside a cylinder
// Rotates and translates each vertex, removes its component along the
// cylinder axis and passes its index on when the squared perpendicular
// distance is at least the radius squared and the index is below MAX_VERTS.
//
//   channel | dir | handshake          | contents
//   --------+-----+--------------------+-------------------------------------
//   s_*     | in  | s_tvalid/s_tready  | vertex_index, vertex_x/y/z
//   m_*     | out | m_tvalid/m_tready  | outside_index
//   cfg_*   | in  | cfg_write          | register cfg_index <= cfg_data
//
// One vertex per cycle while the output is not stalled; a result passes through
// the 11 register stages (rotate 2, projection 4, distance 5).
// Reset (rst, synchronous) empties every stage and loads the register
// defaults; no clearing pass. Each stage holds while its successor is full,
// so a stalled output fills bubbles upstream before s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_cylinder_outside_test import vco_pkg::*; #(
  parameter int MAX_VERTS   = 4096,
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Input vertices
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // [11:0] vertex_index, [27:12] vertex_x, [43:28] vertex_y, [59:44] vertex_z
  input  wire logic [IN_TDATA_W-1:0] s_tdata,
  // Outside vertex indexes
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // [11:0] outside_index
  output logic [OUT_TDATA_W-1:0]     m_tdata,
  // Configuration writes
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [REG_W-1:0]      cfg_data
);

  logic [REG_W-1:0]    row_a, row_b, row_c, centre, origin, axis;
  logic [RADIUS_W-1:0] radius;
  cfg_t                cfg;
  in_item_t            in_item;

  logic       rot_valid, rot_ready;
  rot_item_t  rot_item;
  logic       proj_valid, proj_ready;
  proj_item_t proj_item;
  logic [IDX_W-1:0] out_idx;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_a  <= ROW_A_RST;
      row_b  <= ROW_B_RST;
      row_c  <= ROW_C_RST;
      centre <= '0;
      origin <= '0;
      axis   <= AXIS_RST;
      radius <= RADIUS_RST;
    end else if (cfg_write) begin
      case (cfg_reg_e'(cfg_index))
        CFG_ROW_A:  row_a  <= cfg_data;
        CFG_ROW_B:  row_b  <= cfg_data;
        CFG_ROW_C:  row_c  <= cfg_data;
        CFG_CENTRE: centre <= cfg_data;
        CFG_ORIGIN: origin <= cfg_data;
        CFG_AXIS:   axis   <= cfg_data;
        CFG_RADIUS: radius <= cfg_data[RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.rows[0] = lane3_t'(row_a);
  assign cfg.rows[1] = lane3_t'(row_b);
  assign cfg.rows[2] = lane3_t'(row_c);
  assign cfg.centre  = lane3_t'(centre);
  assign cfg.origin  = lane3_t'(origin);
  assign cfg.axis    = lane3_t'(axis);
  assign cfg.radius  = radius;

  // Unpack the input transfer
  assign in_item = in_item_t'(s_tdata[$bits(in_item_t)-1:0]);

  vco_rot #(
    .MAX_VERTS   (MAX_VERTS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_rot (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .out_valid (rot_valid),
    .out_ready (rot_ready),
    .out_item  (rot_item)
  );

  vco_proj u_proj (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (rot_valid),
    .in_ready  (rot_ready),
    .in_item   (rot_item),
    .out_valid (proj_valid),
    .out_ready (proj_ready),
    .out_item  (proj_item)
  );

  vco_dist u_dist (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (proj_valid),
    .in_ready  (proj_ready),
    .in_item   (proj_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_idx   (out_idx)
  );

  assign m_tdata = {(OUT_TDATA_W - IDX_W)'(0), out_idx};

  // Reset leaves every stage empty
  a_reset_empty: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid)
    else $error("pipeline not empty after reset");

  // Input back-pressure only when every stage is full behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled with room in the pipeline");

  // Only in-range indexes come out
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ({20'd0, out_idx} < 32'(MAX_VERTS)))
    else $error("result index beyond the mesh");

endmodule

`default_nettype wire

// ===== bench/tb_vertex_cylinder_outside_test.sv =====
// ----------------------------------------------------------------------------
// tb_vertex_cylinder_outside_test - bench for the cylinder outside test
// Streams hull vertices through the block and predicts, with exact wide
// integer math, which indexes lie at or beyond the configured radius. Each
// output transfer is matched in order against the predicted index queue.
// Directed cases cover the radius boundary, zero radius and extreme
// register values. Random setups then run under three back-pressure mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_vertex_cylinder_outside_test;
  import vco_pkg::*;

  localparam int SEG_ITEMS    = 100;
  localparam int SEGS_PER_MIX = 4;
  localparam int DRAIN_CYCLES = 24;

  // Wide enough for the squared distance (under 2^130) with sign
  typedef logic signed [191:0] sq_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = CFG_ROW_A;
  logic [REG_W-1:0]       cfg_data = '0;

  // Mirror of the block's registers
  logic [REG_W-1:0]    rot_row [3];
  logic [REG_W-1:0]    centre_q;
  logic [REG_W-1:0]    origin_q;
  logic [REG_W-1:0]    axis_q;
  logic [RADIUS_W-1:0] radius_q;

  logic [IDX_W-1:0] outside_q [$];
  logic [IDX_W-1:0] exp_idx;
  int               err_count = 0;
  int               src_idle_pct = 0;
  int               snk_idle_pct = 0;
  bit               hold_ready = 1'b0;

  vertex_cylinder_outside_test dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // [11:0] index, [27:12] x, [43:28] y, [59:44] z
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // [11:0] outside index
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic longint lane_of(logic [REG_W-1:0] r, int k);
    return longint'($signed(r[LANE_W*k +: LANE_W]));
  endfunction

  function automatic logic [REG_W-1:0] pack3(logic [15:0] x, logic [15:0] y,
                                             logic [15:0] z);
    return {z, y, x};
  endfunction

  // True when the rotated, shifted vertex is at or beyond the radius
  function automatic bit reaches_radius(logic [15:0] vx, logic [15:0] vy,
                                        logic [15:0] vz);
    longint p [3];
    longint pos [3];
    longint ax [3];
    longint proj;
    sq_t    perp;
    sq_t    dist2;
    sq_t    thr;
    p[0] = longint'($signed(vx));
    p[1] = longint'($signed(vy));
    p[2] = longint'($signed(vz));
    proj = 0;
    for (int i = 0; i < 3; i++) begin
      pos[i] = (lane_of(centre_q, i) - lane_of(origin_q, i)) * 16384;
      for (int k = 0; k < 3; k++)
        pos[i] += lane_of(rot_row[i], k) * p[k];
      ax[i] = lane_of(axis_q, i);
      proj += ax[i] * pos[i];
    end
    dist2 = '0;
    for (int i = 0; i < 3; i++) begin
      perp  = (sq_t'(pos[i]) <<< 28) - sq_t'(proj) * sq_t'(ax[i]);
      dist2 = dist2 + perp * perp;
    end
    thr = (sq_t'(radius_q) * sq_t'(radius_q)) <<< 84;
    return dist2 >= thr;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Random back-pressure, or steady ready while draining
  always @(negedge clk) begin
    m_tready <= hold_ready || ($urandom_range(99) >= snk_idle_pct);
  end

  task automatic send_vertex(logic [IDX_W-1:0] idx, logic [15:0] vx,
                             logic [15:0] vy, logic [15:0] vz);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, vz, vy, vx, idx};
    do @(posedge clk); while (!s_tready);
    if (reaches_radius(vx, vy, vz))
      outside_q.push_back(idx);
  endtask

  task automatic write_reg(cfg_reg_e which, logic [REG_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (which)
      CFG_ROW_A:  rot_row[0] = value;
      CFG_ROW_B:  rot_row[1] = value;
      CFG_ROW_C:  rot_row[2] = value;
      CFG_CENTRE: centre_q   = value;
      CFG_ORIGIN: origin_q   = value;
      CFG_AXIS:   axis_q     = value;
      CFG_RADIUS: radius_q   = value[RADIUS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all_regs(logic [REG_W-1:0] value);
    cfg_reg_e r;
    r = r.first();
    do begin
      write_reg(r, value);
      r = r.next();
    end while (r != r.first());
  endtask

  // Stop sending and wait for every predicted index
  task automatic pause_until_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (outside_q.size() != 0) @(posedge clk);
  endtask

  // Drain, then let silent items clear the pipeline
  task automatic settle();
    pause_until_drained();
    hold_ready = 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk);
    hold_ready = 1'b0;
  endtask

  function automatic logic [15:0] small_coord();
    return 16'($urandom_range(2047)) - 16'd1024;
  endfunction

  // Mostly signed permutation rows and unit axes, some arbitrary entries
  task automatic load_random_setup();
    int               perm [3];
    int               j;
    int               t;
    logic [15:0]      one;
    logic [REG_W-1:0] val;
    perm = '{0, 1, 2};
    for (int i = 0; i < 2; i++) begin
      j       = $urandom_range(2, i);
      t       = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    for (int i = 0; i < 3; i++) begin
      one = $urandom_range(1) ? 16'h4000 : 16'hC000;
      if ($urandom_range(9) < 6)
        val = REG_W'(one) << (LANE_W * perm[i]);
      else
        val = REG_W'({$urandom(), $urandom()});
      write_reg(cfg_reg_e'(CFG_ROW_A + i), val);
    end
    val = $urandom_range(1) ? pack3(small_coord(), small_coord(), small_coord())
                            : REG_W'({$urandom(), $urandom()});
    write_reg(CFG_CENTRE, val);
    val = $urandom_range(1) ? pack3(small_coord(), small_coord(), small_coord())
                            : REG_W'({$urandom(), $urandom()});
    write_reg(CFG_ORIGIN, val);
    one = $urandom_range(1) ? 16'h4000 : 16'hC000;
    if ($urandom_range(9) < 7)
      val = REG_W'(one) << (LANE_W * $urandom_range(2));
    else
      val = REG_W'({$urandom(), $urandom()});
    write_reg(CFG_AXIS, val);
    val = ($urandom_range(9) < 3) ? REG_W'($urandom_range(65535))
                                  : REG_W'($urandom_range(1024));
    write_reg(CFG_RADIUS, val);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Default registers: identity rotation, z axis, radius 1.0
  task automatic test_boundary_at_reset();
    send_vertex(12'd0,   16'd256,  16'd0,    16'd0);     // exactly on radius
    send_vertex(12'd1,   16'd255,  16'd0,    16'd0);     // just inside
    send_vertex(12'hFFF, 16'd0,    16'd0,    16'h7FFF);  // on the axis
    send_vertex(12'hAAA, 16'h7FFF, 16'h7FFF, 16'h8000);
    send_vertex(12'h555, 16'h8000, 16'h8000, 16'h7FFF);
    send_vertex(12'd7,   16'd0,    16'hFF00, 16'h8000);  // on radius, negative y
    send_vertex(12'd8,   16'hFFFF, 16'hFFFF, 16'd0);
    settle();
  endtask

  // Zero radius passes every vertex, even on the axis
  task automatic test_zero_radius();
    write_reg(CFG_RADIUS, '0);
    send_vertex(12'd9,   16'd0,    16'd0,    16'd0);
    send_vertex(12'd10,  16'd0,    16'd0,    16'h7FFF);
    send_vertex(12'd11,  16'd1,    16'd0,    16'h8000);
    settle();
  endtask

  // Non-orthonormal rotation and non-unit axis at the lane extremes
  task automatic test_extreme_registers();
    write_reg(CFG_ROW_A,  48'h7FFF_7FFF_7FFF);
    write_reg(CFG_ROW_B,  48'h7FFF_7FFF_7FFF);
    write_reg(CFG_ROW_C,  48'h8000_8000_8000);
    write_reg(CFG_CENTRE, 48'h7FFF_7FFF_7FFF);
    write_reg(CFG_ORIGIN, 48'h8000_8000_8000);
    write_reg(CFG_AXIS,   48'h8000_8000_8000);
    write_reg(CFG_RADIUS, 48'h0000_0000_FFFF);
    send_vertex(12'hFFF, 16'h8000, 16'h8000, 16'h8000);
    send_vertex(12'd0,   16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_vertex(12'd12,  16'h0000, 16'h0000, 16'h0000);
    send_vertex(12'd13,  16'h7FFF, 16'h8000, 16'h7FFF);
    settle();
    write_all_regs('1);
    send_vertex(12'd14,  16'h8000, 16'h7FFF, 16'h8000);
    send_vertex(12'd15,  16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_vertex(12'd16,  16'h0000, 16'h0000, 16'h0000);
    settle();
    write_all_regs('0);
    send_vertex(12'd17,  16'h7FFF, 16'h8000, 16'h7FFF);
    send_vertex(12'd18,  16'h0000, 16'h0000, 16'h0000);
    settle();
  endtask

  task automatic send_random_vertex();
    logic [IDX_W-1:0] idx;
    idx = IDX_W'($urandom_range(4095));
    if ($urandom_range(1))
      send_vertex(idx, 16'($urandom), 16'($urandom), 16'($urandom));
    else
      send_vertex(idx, small_coord(), small_coord(), small_coord());
  endtask

  task automatic test_random_stream(int src_pct, int snk_pct);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    for (int seg = 0; seg < SEGS_PER_MIX; seg++) begin
      load_random_setup();
      for (int n = 0; n < SEG_ITEMS; n++) begin
        if (seg == 1 && n == SEG_ITEMS / 2)
          pause_until_drained();
        send_random_vertex();
      end
      settle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output check: match each transfer against the oldest predicted index
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (outside_q.size() == 0) begin
        $display("%0t: unexpected outside_index %0d, expected none", $time,
                 m_tdata[IDX_W-1:0]);
        err_count++;
      end else begin
        exp_idx = outside_q.pop_front();
        if (m_tdata[IDX_W-1:0] !== exp_idx) begin
          $display("%0t: outside_index mismatch: expected %0d, actual %0d",
                   $time, exp_idx, m_tdata[IDX_W-1:0]);
          err_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rot_row[0] = ROW_A_RST;
    rot_row[1] = ROW_B_RST;
    rot_row[2] = ROW_C_RST;
    centre_q   = '0;
    origin_q   = '0;
    axis_q     = AXIS_RST;
    radius_q   = RADIUS_RST;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    src_idle_pct = 21;
    snk_idle_pct = 81;
    test_boundary_at_reset();
    test_zero_radius();
    test_extreme_registers();
    test_random_stream(21, 81);
    test_random_stream(81, 21);
    test_random_stream(0, 0);
    settle();

    if (err_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // Hang guard
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
